FILE: sv/ctd_pkg.sv
// package for the clock tempo detector: widths, register indexes, duration factors
// no dependencies
`default_nettype none
package ctd_pkg;
  localparam int NUM_DURATIONS_DEF = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_KNOB = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TPM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TMO = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW = 3'd5;
  localparam logic [9:0] OOR_BPM = 10'd999;
  localparam logic [8:0] MIN_KNOB = 9'd30;
  localparam logic [21:0] US_PER_48TH = 22'd1250000;
  localparam int DIV_W = 32;

  // note factor in 48ths of a beat
  function automatic logic [7:0] factor48(input logic [3:0] k);
    case (k)
      4'd0: factor48 = 8'd192;
      4'd1: factor48 = 8'd144;
      4'd2: factor48 = 8'd96;
      4'd3: factor48 = 8'd64;
      4'd4: factor48 = 8'd72;
      4'd5: factor48 = 8'd48;
      4'd6: factor48 = 8'd32;
      4'd7: factor48 = 8'd36;
      4'd8: factor48 = 8'd24;
      4'd9: factor48 = 8'd16;
      4'd10: factor48 = 8'd18;
      4'd11: factor48 = 8'd12;
      4'd12: factor48 = 8'd8;
      4'd13: factor48 = 8'd9;
      4'd14: factor48 = 8'd6;
      default: factor48 = 8'd4;
    endcase
  endfunction

  // controller to datapath
  typedef struct packed {
    logic step;      // evaluate trigger, lock and counters for the item
    logic div_bpm;   // start bpm division
    logic take_bpm;  // apply bpm division result
    logic div_dur;   // start duration division
    logic emit_done; // commit last_computed_bpm
  } ctd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_bpm;  // locked after step
    logic emit;      // durations required
    logic div_busy;
  } ctd_sts_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_BPM  = 5'b00010,
    S_STAT = 5'b00100,
    S_DUR  = 5'b01000,
    S_DOUT = 5'b10000
  } ctd_state_t;
endpackage
`default_nettype wire

FILE: sv/ctd_if.sv
// valid/ready channel interface with payload
// depends on nothing
`default_nettype none
interface ctd_if #(parameter int W = 16) (input logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/ctd_div.sv
// restoring divider, one quotient bit per cycle, rounds half up
// uses ctd_pkg
`default_nettype none
module ctd_div import ctd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  num,   // already 2*n+d
  input  wire logic [DIV_W-1:0]  den,   // already 2*d, nonzero
  output logic                   busy,
  output logic [DIV_W-1:0]       quo
);
  logic [DIV_W-1:0] q_r, q_nxt, d_r, d_nxt;
  logic [DIV_W:0] rem_r, rem_nxt, trial;
  logic [5:0] cnt_r, cnt_nxt;
  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    trial = {rem_r[DIV_W-1:0], q_r[DIV_W-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt = num; d_nxt = den; rem_nxt = '0; cnt_nxt = 6'(DIV_W);
    end else if (cnt_r != 6'd0) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!trial[DIV_W]) begin
        rem_nxt = trial;
        q_nxt = {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DIV_W-1:0], q_r[DIV_W-1]};
        q_nxt = {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end
  assign busy = (cnt_r != 6'd0) || start;
  assign quo = q_r;
endmodule
`default_nettype wire

FILE: sv/ctd_datapath.sv
// datapath: trigger, lock tracking, tempo and durations, output register
// uses ctd_pkg, ctd_div
`default_nettype none
module ctd_datapath import ctd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_dat,
  input  wire logic                  in_conn,
  input  wire logic signed [14:0]    in_smp,
  input  wire ctd_cmd_t              cmd,
  input  wire logic [3:0]            dur_idx,
  output ctd_sts_t                   sts,
  output logic [9:0]                 bpm,
  output logic                       lock,
  output logic                       oor,
  output logic [27:0]                dur_us
);
  logic [8:0] knob_r; logic [23:0] tpm_r, tmo_r; logic [15:0] jit_r;
  logic signed [14:0] hi_r, lo_r;
  logic trig_r, mem_r, lock_r, emit_r;
  logic [1:0] ecnt_r;
  logic [23:0] tse_r, per_r;
  logic [9:0] bpm_r, lastb_r;
  logic [DIV_W-1:0] dnum, dden, quo;
  logic dbusy, dstart;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knob_r <= 9'd120; tpm_r <= 24'd2880000; jit_r <= 16'd24;
      tmo_r <= 24'd96000; hi_r <= 15'sd1000; lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KNOB: knob_r <= cfg_dat[8:0];
        REG_TPM:  tpm_r <= cfg_dat;
        REG_JIT:  jit_r <= cfg_dat[15:0];
        REG_TMO:  tmo_r <= cfg_dat;
        REG_HIGH: hi_r <= cfg_dat[14:0];
        REG_LOW:  lo_r <= cfg_dat[14:0];
        default: ;
      endcase
    end
  end

  // per-item step
  logic trig_n, mem_n, lock_n, rise, emit_n;
  logic [1:0] ecnt_n; logic [23:0] tse_n, per_n, dlt; logic [9:0] bpm_n, knobc;
  always_comb begin
    trig_n = trig_r; mem_n = mem_r; lock_n = lock_r; ecnt_n = ecnt_r;
    tse_n = tse_r; per_n = per_r; bpm_n = bpm_r; emit_n = 1'b0; rise = 1'b0;
    knobc = (knob_r < MIN_KNOB) ? {1'b0, MIN_KNOB} : {1'b0, knob_r};
    dlt = (per_r > tse_r) ? per_r - tse_r : tse_r - per_r;
    if (in_conn) begin
      if (trig_r) begin
        if (in_smp <= lo_r) trig_n = 1'b0;
      end else if (in_smp >= hi_r) begin
        trig_n = 1'b1; rise = 1'b1;
      end
      if (rise && !mem_r) begin
        if (ecnt_r != 2'd3) ecnt_n = ecnt_r + 2'd1;
        mem_n = 1'b1;
        if (ecnt_n == 2'd2) begin
          lock_n = 1'b1; per_n = tse_r;
        end else if (ecnt_n == 2'd3 && dlt > {8'd0, jit_r}) begin
          lock_n = 1'b0; ecnt_n = 2'd0;
        end
        tse_n = '0;
      end
      if (in_smp <= lo_r && mem_n) mem_n = 1'b0;
    end else begin
      lock_n = 1'b0; ecnt_n = 2'd0; bpm_n = knobc;
      emit_n = (knobc != lastb_r);
    end
  end

  // tick counting and timeout, after the tempo when locked
  logic cnt_now;
  logic [23:0] tse_src, tse_cnt;
  assign cnt_now = cmd.take_bpm || (cmd.step && in_conn && !lock_n);
  assign tse_src = cmd.step ? tse_n : tse_r;
  assign tse_cnt = (tse_src != 24'hFFFFFF) ? tse_src + 24'd1 : tse_src;

  // bpm result with clamps
  logic [9:0] bq; logic bov;
  assign bov = (quo >= DIV_W'(OOR_BPM));
  assign bq = (quo == '0) ? 10'd1 : quo[9:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r <= 1'b0; mem_r <= 1'b0; lock_r <= 1'b0; ecnt_r <= '0;
      tse_r <= '0; per_r <= '0; bpm_r <= 10'd120; lastb_r <= '0; emit_r <= 1'b0;
    end else begin
      if (cmd.step) begin
        trig_r <= trig_n; mem_r <= mem_n; per_r <= per_n;
        bpm_r <= bpm_n; emit_r <= emit_n;
      end
      if (cmd.take_bpm) begin
        if (bov) bpm_r <= OOR_BPM;
        else begin
          bpm_r <= bq; emit_r <= (bq != lastb_r);
        end
      end
      // counting and timeout at the step, or once the tempo is settled when locked
      if (cnt_now) begin
        tse_r <= tse_cnt;
        if (tse_cnt > tmo_r) begin
          lock_r <= 1'b0; ecnt_r <= '0;
        end else if (cmd.step) begin
          lock_r <= lock_n; ecnt_r <= ecnt_n;
        end
      end else if (cmd.step) begin
        tse_r <= tse_n; lock_r <= lock_n; ecnt_r <= ecnt_n;
      end
      if (cmd.emit_done) lastb_r <= bpm_r;
    end
  end

  // divider operands
  logic [31:0] per1, pdur;
  assign per1 = (per_r == '0) ? 32'd1 : {8'd0, per_r};
  assign pdur = US_PER_48TH * factor48(dur_idx);
  always_comb begin
    if (cmd.div_bpm) begin
      dnum = {7'd0, tpm_r, 1'b0} + per1; dden = {per1[30:0], 1'b0};
    end else begin
      dnum = {pdur[30:0], 1'b0} + {22'd0, bpm_r};
      dden = {21'd0, bpm_r, 1'b0};
    end
  end
  assign dstart = cmd.div_bpm || cmd.div_dur;

  ctd_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
    .busy(dbusy), .quo(quo));

  assign sts.need_bpm = lock_r;
  assign sts.emit = emit_r;
  assign sts.div_busy = dbusy;
  assign bpm = bpm_r;
  assign lock = lock_r;
  assign oor = lock_r && (bpm_r >= OOR_BPM);
  assign dur_us = quo[27:0];
endmodule
`default_nettype wire

FILE: sv/ctd_ctrl.sv
// controller: sequences one item through step, division and result delivery
// uses ctd_pkg
`default_nettype none
module ctd_ctrl import ctd_pkg::*; #(
  parameter int NUM_DURATIONS = NUM_DURATIONS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_fire,
  input  wire logic     in_conn,
  input  wire logic     out_take,
  input  wire ctd_sts_t sts,
  output ctd_cmd_t      cmd,
  output logic          in_rdy,
  output logic          out_vld,
  output logic          is_dur,
  output logic [3:0]    idx,
  output logic          is_last
);
  ctd_state_t st_r, st_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic wait_r, wait_nxt;
  ctd_cmd_t cmd_c;
  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; wait_nxt = wait_r; cmd_c = '0;
    case (st_r)
      S_IDLE: if (in_fire) begin
        cmd_c.step = 1'b1;
        if (in_conn) begin
          st_nxt = S_BPM; wait_nxt = 1'b1;
        end else st_nxt = S_STAT;
      end
      S_BPM: begin
        // check lock after step, then divide
        if (wait_r) begin
          if (sts.need_bpm) begin
            cmd_c.div_bpm = 1'b1; wait_nxt = 1'b0;
          end else st_nxt = S_STAT;
        end else if (!sts.div_busy) begin
          cmd_c.take_bpm = 1'b1; st_nxt = S_STAT;
        end
      end
      S_STAT: if (out_take) begin
        if (sts.emit) begin
          idx_nxt = '0; cmd_c.div_dur = 1'b1; st_nxt = S_DUR;
        end else st_nxt = S_IDLE;
      end
      S_DUR: if (!sts.div_busy) st_nxt = S_DOUT;
      S_DOUT: if (out_take) begin
        if (idx_r == 4'(NUM_DURATIONS - 1)) begin
          cmd_c.emit_done = 1'b1; idx_nxt = '0; st_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + 4'd1; st_nxt = S_DUR;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_DUR && st_r == st_nxt) cmd_c.div_dur = 1'b0;
  end
  // restart divider on index change
  logic kick_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; idx_r <= '0; wait_r <= 1'b0; kick_r <= 1'b0;
    end else begin
      st_r <= st_nxt; idx_r <= idx_nxt; wait_r <= wait_nxt;
      kick_r <= (st_r == S_DOUT) && out_take && (st_nxt == S_DUR);
    end
  end
  // divide for the next index is started the cycle after it is latched
  ctd_cmd_t cmd_o;
  always_comb begin
    cmd_o = cmd_c;
    if (kick_r) cmd_o.div_dur = 1'b1;
  end
  assign cmd = cmd_o;
  assign in_rdy = (st_r == S_IDLE);
  assign out_vld = (st_r == S_STAT) || (st_r == S_DOUT);
  assign is_dur = (st_r == S_DOUT);
  assign idx = idx_r;
  assign is_last = (st_r == S_STAT) ? !sts.emit : (idx_r == 4'(NUM_DURATIONS - 1));
endmodule
`default_nettype wire

FILE: sv/clock_tempo_detector.sv
// Clock tempo detector top level.
// Input channel in: one item per audio tick, payload {clock_connected, clock_sample}.
// Output channel out: one status item per tick, then 16 note duration items
// whenever the tempo changes; last marks the final item of a tick.
// Config channel cfg: index 0..5 selects knob_bpm, ticks_per_minute,
// jitter_ticks, timeout_ticks, high_threshold, low_threshold.
// Timing: a locked tick computes its tempo with one 32-step restoring divider,
// shared with the note durations, before its status item is offered; a
// disconnected or an unlocked connected tick skips the division. Each duration
// item is divided after the previous item of the tick is taken.
// One item is processed at a time; in is ready the cycle after the previous
// tick's last item is delivered. A stalled receiver holds the current
// result and the sequencer waits. Synchronous active-low reset restores all
// register defaults and detector state; no clearing pass is needed.
`default_nettype none
module clock_tempo_detector import ctd_pkg::*; #(
  parameter int NUM_DURATIONS = NUM_DURATIONS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  ctd_if.sink      in_ch,
  ctd_if.source    out_ch,
  ctd_if.sink      cfg_ch
);
  ctd_cmd_t cmd; ctd_sts_t sts;
  logic [9:0] bpm; logic lock, oor, is_dur, is_last; logic [3:0] idx;
  logic [27:0] dur;
  logic in_fire, out_take;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_take = out_ch.valid && out_ch.ready;
  assign cfg_ch.ready = 1'b1;

  ctd_ctrl #(.NUM_DURATIONS(NUM_DURATIONS)) u_ctrl (.clk(clk), .rst_n(rst_n),
    .in_fire(in_fire), .in_conn(in_ch.data[15]), .out_take(out_take), .sts(sts),
    .cmd(cmd), .in_rdy(in_ch.ready), .out_vld(out_ch.valid), .is_dur(is_dur),
    .idx(idx), .is_last(is_last));

  ctd_datapath u_dp (.clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.data[26:24]), .cfg_dat(cfg_ch.data[23:0]),
    .in_conn(in_ch.data[15]), .in_smp(in_ch.data[14:0]), .cmd(cmd),
    .dur_idx(idx), .sts(sts), .bpm(bpm), .lock(lock), .oor(oor), .dur_us(dur));

  // payload {kind, tempo_bpm, locked, out_of_range, duration_index, duration_us, last}
  assign out_ch.data = {is_dur, bpm, lock, oor, is_dur ? idx : 4'd0,
    is_dur ? dur : 28'd0, is_last};
endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench for the clock tempo detector: pulse trains and noise in, status and note items checked
// depends on ctd_pkg, ctd_if and clock_tempo_detector
`default_nettype none

module tb_top;
  import ctd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W = 16;
  localparam int OUT_W = 46;
  localparam int CFG_W = CFG_IDX_W + CFG_DATA_W;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 700;

  typedef struct packed {
    logic        kind;
    logic [9:0]  tempo_bpm;
    logic        locked;
    logic        out_of_range;
    logic [3:0]  duration_index;
    logic [27:0] duration_us;
    logic        last;
  } tempo_res_t;

  // tempo tracker mirror and expected item store
  class tempo_scoreboard;
    int unsigned knob, tpm, jitter, tmo;
    int hi_thr, lo_thr;
    bit trig_high, edge_mem, lock_on;
    int unsigned edges, since_edge, period, bpm_now, bpm_prev;
    int unsigned fac[16];
    tempo_res_t pending[$];
    int errors;

    function new();
      knob = 120; tpm = 2880000; jitter = 24; tmo = 96000;
      hi_thr = 1000; lo_thr = 0;
      trig_high = 0; edge_mem = 0; lock_on = 0;
      edges = 0; since_edge = 0; period = 0; bpm_now = 120; bpm_prev = 0;
      fac = '{192, 144, 96, 64, 72, 48, 32, 36, 24, 16, 18, 12, 8, 9, 6, 4};
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_KNOB: knob = v[8:0];
        REG_TPM:  tpm = v;
        REG_JIT:  jitter = v[15:0];
        REG_TMO:  tmo = v;
        REG_HIGH: hi_thr = $signed(v[14:0]);
        REG_LOW:  lo_thr = $signed(v[14:0]);
        default: ;
      endcase
    endfunction

    function void note(bit conn, logic [14:0] raw);
      int s;
      bit rise, emit;
      int unsigned dev, n;
      longint unsigned p, b, num;
      tempo_res_t r;
      s = $signed(raw);
      emit = 0;
      if (conn) begin
        rise = 0;
        if (trig_high) begin
          if (s <= lo_thr) trig_high = 0;
        end else if (s >= hi_thr) begin
          trig_high = 1;
          rise = 1;
        end
        if (rise && !edge_mem) begin
          if (edges < 3) edges++;
          edge_mem = 1;
          if (edges == 2) begin
            lock_on = 1;
            period = since_edge;
          end else if (edges > 2) begin
            dev = (period > since_edge) ? period - since_edge : since_edge - period;
            if (dev > jitter) begin
              lock_on = 0;
              edges = 0;
            end
          end
          since_edge = 0;
        end
        if (s <= lo_thr && edge_mem) edge_mem = 0;
        if (lock_on) begin
          p = (period != 0) ? period : 1;
          b = (2 * longint'(tpm) + p) / (2 * p);
          if (b < 1) b = 1;
          if (b >= OOR_BPM) bpm_now = OOR_BPM;
          else begin
            bpm_now = 32'(b);
            if (bpm_now != bpm_prev) emit = 1;
          end
        end
        if (since_edge < 24'hFFFFFF) since_edge++;
        if (since_edge > tmo) begin
          lock_on = 0;
          edges = 0;
        end
      end else begin
        lock_on = 0;
        edges = 0;
        bpm_now = (knob < MIN_KNOB) ? MIN_KNOB : knob;
        if (bpm_now != bpm_prev) emit = 1;
      end
      n = emit ? 17 : 1;
      for (int k = 0; k < n; k++) begin
        r.kind = (k != 0);
        r.tempo_bpm = 10'(bpm_now);
        r.locked = lock_on;
        r.out_of_range = lock_on && bpm_now >= OOR_BPM;
        r.duration_index = (k != 0) ? 4'(k - 1) : 4'd0;
        if (k != 0) begin
          num = 64'd1250000 * fac[k-1];
          b = (bpm_now != 0) ? bpm_now : 1;
          r.duration_us = 28'((2 * num + b) / (2 * b));
        end else r.duration_us = 0;
        r.last = (k == n - 1);
        pending.push_back(r);
      end
      if (emit) bpm_prev = bpm_now;
    endfunction

    function void check(tempo_res_t got);
      tempo_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind || got.tempo_bpm != want.tempo_bpm ||
          got.locked != want.locked || got.out_of_range != want.out_of_range ||
          got.duration_index != want.duration_index ||
          got.duration_us != want.duration_us || got.last != want.last) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int cycles = 0;
  int mode = 0;
  tempo_scoreboard sb = new();

  ctd_if #(.W(IN_W)) in_ch (clk);
  ctd_if #(.W(OUT_W)) out_ch (clk);
  ctd_if #(.W(CFG_W)) cfg_ch (clk);

  clock_tempo_detector DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls by phase
  always @(negedge clk) begin
    if (mode == 2) out_ch.ready <= ($urandom_range(99) >= 79);
    else if (mode == 3) out_ch.ready <= ($urandom_range(99) >= 21);
    else out_ch.ready <= 1'b1;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.data);
  end

  // one tick item; called and returns at a falling edge
  task automatic send_tick(bit conn, int mv);
    bit taken;
    int idle_pct;
    idle_pct = (mode == 1) ? 79 : 21;
    if ((mode == 1 || mode == 3) && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= {conn, 15'(mv)};
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      if (in_ch.ready) begin
        taken = 1;
        sb.note(conn, 15'(mv));
      end
      @(negedge clk);
    end
  endtask

  // wait until every expected item has come and the block has settled
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
    bit taken;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= {idx, 24'(v)};
    taken = 0;
    while (!taken) begin
      @(posedge clk);
      if (cfg_ch.ready) begin
        taken = 1;
        sb.set_reg(idx, 24'(v));
      end
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup(int unsigned kb, int unsigned tp, int unsigned jt, int unsigned to,
                       int hi, int lo);
    write_reg(REG_KNOB, kb);
    write_reg(REG_TPM, tp);
    write_reg(REG_JIT, jt);
    write_reg(REG_TMO, to);
    write_reg(REG_HIGH, hi);
    write_reg(REG_LOW, lo);
  endtask

  function automatic int pick(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // random part: mostly pulse trains, some noise and disconnects
  task automatic random_ticks(int count);
    int sent, per, hlen, hi, lo;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(9))
        0: begin
          send_tick(0, pick(-12000, 12000));
          sent++;
        end
        1, 2: begin
          repeat (pick(1, 6)) begin
            send_tick($urandom_range(1), pick(-12000, 12000));
            sent++;
          end
        end
        default: begin
          per = pick(2, 16);
          hi = (sb.hi_thr > 12000) ? 12000 : sb.hi_thr;
          lo = (sb.lo_thr < -12000) ? -12000 : sb.lo_thr;
          repeat (pick(3, 8)) begin
            hlen = pick(1, per - 1);
            if ($urandom_range(5) == 0) hlen = pick(1, per + 3);
            repeat (hlen) begin
              send_tick(1, pick(hi, 12000));
              sent++;
            end
            repeat ((per > hlen) ? per - hlen : 1) begin
              send_tick(1, pick(-12000, lo));
              sent++;
            end
          end
        end
      endcase
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: knob floor, lock, steady edge, jitter drop, extremes
    setup(0, 1200, 0, 200, 1000, 0);
    send_tick(0, 0);
    send_tick(1, -12000);
    send_tick(1, 12000);
    send_tick(1, -12000);
    send_tick(1, -12000);
    send_tick(1, 12000);
    send_tick(1, -12000);
    send_tick(1, -12000);
    send_tick(1, -1);
    send_tick(1, 12000);
    send_tick(1, -12000);
    send_tick(1, 12000);
    send_tick(1, 12000);
    send_tick(1, 0);
    send_tick(0, 12000);
    send_tick(0, -12000);
    drain();

    mode = 0;
    random_ticks(70);
    drain();

    setup(511, 60, 65535, 24'hFFFFFF, 12000, -12000);
    mode = 1;
    random_ticks(70);
    drain();

    setup(300, 11520000, 3, 1, -12000, 12000);
    mode = 2;
    random_ticks(50);
    drain();

    setup(30, 0, 24, 96000, 500, -500);
    mode = 3;
    random_ticks(60);
    drain();

    setup(200, 2400, 2, 500, 2000, 1000);
    mode = 0;
    random_ticks(30);
    // sender holds off until the block has caught up
    drain();
    mode = 3;
    random_ticks(40);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

`default_nettype wire

FILE: files.f
sv/ctd_pkg.sv
sv/ctd_if.sv
sv/ctd_div.sv
sv/ctd_datapath.sv
sv/ctd_ctrl.sv
sv/clock_tempo_detector.sv
tb/sv/tb_top.sv
